// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the clocked checks at the end of a module.
// Each check runs on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmcr_pkg.sv =====
`timescale 1ns / 1ps

package tmcr_pkg;

    localparam int MEM_ADDR_BITS   = 16;
    localparam int MEM_DEPTH       = 1 << MEM_ADDR_BITS;
    localparam int CELL_W          = 10;
    localparam int DEF_COLUMNS     = 22;
    localparam int DEF_ROWS        = 23;
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    localparam logic [MEM_ADDR_BITS-1:0] COLOUR_BASE = 16'h9400;

    localparam logic KIND_STORE  = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    localparam logic [1:0] REG_BANK_SELECT      = 2'd0;
    localparam logic [1:0] REG_ADDRESS_BIT_NINE = 2'd1;
    localparam logic [1:0] REG_BACKGROUND       = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_group;
        logic [7:0]  scan_line;
        logic [4:0]  cell_column;
        logic        frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] bank_select;
        logic       address_bit_nine;
        logic [3:0] background_colour;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [15:0]       address;
        logic [7:0]        write_data;
        logic [CELL_W-1:0] cell_index;
        logic [2:0]        glyph_line;
        logic [7:0]        scan_line;
        logic [4:0]        cell_column;
        logic              frame_end;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic pend;
    } t_back_stat;

endpackage

// ===== hw/rtl/tmcr_ram.sv =====
`timescale 1ns / 1ps

module tmcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tmcr_regs.sv =====
`timescale 1ns / 1ps

module tmcr_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tmcr_pkg::PADDR_W-1:0]  paddr,
    input  logic [tmcr_pkg::PDATA_W-1:0]  pwdata,
    output logic [tmcr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output tmcr_pkg::t_cfg                o_cfg
);

    import tmcr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BANK_SELECT:      r_cfg.bank_select       <= pwdata[7:0];
                REG_ADDRESS_BIT_NINE: r_cfg.address_bit_nine  <= pwdata[0];
                REG_BACKGROUND:       r_cfg.background_colour <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BANK_SELECT:      prdata = {24'b0, r_cfg.bank_select};
            REG_ADDRESS_BIT_NINE: prdata = {31'b0, r_cfg.address_bit_nine};
            REG_BACKGROUND:       prdata = {28'b0, r_cfg.background_colour};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/tmcr_front.sv =====
`timescale 1ns / 1ps

module tmcr_front #(
    parameter int COLUMNS = tmcr_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcr_pkg::DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tmcr_pkg::t_in_item i_in_data,
    output logic               o_in_ready,
    input  logic               i_q_full,
    output logic               o_push,
    output tmcr_pkg::t_cmd     o_cmd
);

    import tmcr_pkg::*;

    logic [4:0]        r_col;
    logic [2:0]        r_line;
    logic [4:0]        r_row;
    logic [CELL_W-1:0] r_row_base;
    logic              last_col;
    logic              last_line;
    logic              last_row;
    logic              advance;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign advance    = o_push && (i_in_data.kind == KIND_RENDER);

    assign last_col  = (r_col == 5'(COLUMNS - 1));
    assign last_line = (r_line == 3'd7);
    assign last_row  = (r_row == 5'(ROWS - 1));

    always_comb begin
        o_cmd.kind        = i_in_data.kind;
        o_cmd.address     = i_in_data.address;
        o_cmd.write_data  = i_in_data.write_data;
        o_cmd.cell_index  = r_row_base + CELL_W'(r_col);
        o_cmd.glyph_line  = r_line;
        o_cmd.scan_line   = {r_row, r_line};
        o_cmd.cell_column = r_col;
        o_cmd.frame_end   = last_col && last_line && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_line     <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (advance) begin
            if (!last_col) begin
                r_col <= r_col + 5'd1;
            end else begin
                r_col <= '0;
                if (!last_line) begin
                    r_line <= r_line + 3'd1;
                end else begin
                    r_line <= '0;
                    if (!last_row) begin
                        r_row      <= r_row + 5'd1;
                        r_row_base <= r_row_base + CELL_W'(COLUMNS);
                    end else begin
                        r_row      <= '0;
                        r_row_base <= '0;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/tmcr_queue.sv =====
`timescale 1ns / 1ps

module tmcr_queue #(
    parameter int DEPTH = tmcr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmcr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tmcr_pkg::t_cmd o_cmd,
    output logic           o_overflow
);

    import tmcr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_cmd      = r_slot[r_rd_ptr];
    assign o_overflow = (r_count > CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/tmcr_back.sv =====
`timescale 1ns / 1ps

module tmcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmcr_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  tmcr_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tmcr_pkg::t_out_item o_out_data,
    output tmcr_pkg::t_back_stat o_stat
);

    import tmcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLOUR,
        ST_GLYPH
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_gpend;
    logic              n_gpend;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic [CELL_W-1:0] r_cell;
    logic [2:0]        r_line;
    logic [7:0]        r_scan;
    logic [4:0]        r_col;
    logic              r_end;
    logic [7:0]        r_code;
    logic [3:0]        r_colour;

    logic                     can_emit;
    logic                     stall;
    logic                     emit;
    logic                     start_render;
    logic                     ram_en;
    logic                     ram_we;
    logic [MEM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]               ram_wdata;
    logic [7:0]               ram_rdata;
    logic [MEM_ADDR_BITS-1:0] bit9_ofs;
    logic [MEM_ADDR_BITS-1:0] screen_addr;
    logic [MEM_ADDR_BITS-1:0] colour_addr;
    logic [MEM_ADDR_BITS-1:0] glyph_addr;
    logic [7:0]               shape;

    function automatic logic [MEM_ADDR_BITS-1:0] bank_base(input logic [3:0] nibble);
        return {~nibble[3], 2'b00, nibble[2:0], 10'b0};
    endfunction

    tmcr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign bit9_ofs    = {6'b0, i_cfg.address_bit_nine, 9'b0};
    assign screen_addr = (bank_base(i_cfg.bank_select[7:4]) | bit9_ofs)
                         + MEM_ADDR_BITS'(i_q_cmd.cell_index);
    assign colour_addr = (COLOUR_BASE | bit9_ofs) + MEM_ADDR_BITS'(r_cell);
    assign glyph_addr  = bank_base(i_cfg.bank_select[3:0])
                         + MEM_ADDR_BITS'({r_code, 3'b000}) + MEM_ADDR_BITS'(r_line);

    assign can_emit = !r_out_valid || i_out_ready;
    assign stall    = r_gpend && !can_emit;

    always_comb begin
        n_state      = r_state;
        emit         = 1'b0;
        o_pop        = 1'b0;
        start_render = 1'b0;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = screen_addr;
        ram_wdata    = i_q_cmd.write_data;
        case (r_state)
            ST_IDLE: begin
                if (!stall) begin
                    emit = r_gpend;
                    if (i_q_valid) begin
                        o_pop  = 1'b1;
                        ram_en = 1'b1;
                        if (i_q_cmd.kind == KIND_STORE) begin
                            ram_we   = 1'b1;
                            ram_addr = i_q_cmd.address;
                        end else begin
                            start_render = 1'b1;
                            n_state      = ST_COLOUR;
                        end
                    end
                end
            end
            ST_COLOUR: begin
                ram_en   = 1'b1;
                ram_addr = colour_addr;
                n_state  = ST_GLYPH;
            end
            ST_GLYPH: begin
                ram_en   = 1'b1;
                ram_addr = glyph_addr;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        shape = r_colour[3] ? ~ram_rdata : ram_rdata;
        for (int j = 0; j < 8; j++) begin
            n_out.pixel_group[4*j +: 4] = shape[j] ? {1'b0, r_colour[2:0]}
                                                   : i_cfg.background_colour;
        end
        n_out.scan_line   = r_scan;
        n_out.cell_column = r_col;
        n_out.frame_end   = r_end;
    end

    always_comb begin
        n_gpend = r_gpend;
        if (emit) begin
            n_gpend = 1'b0;
        end
        if (r_state == ST_GLYPH) begin
            n_gpend = 1'b1;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gpend     <= n_gpend;
            r_out_valid <= n_out_valid;
            if (start_render) begin
                r_cell <= i_q_cmd.cell_index;
                r_line <= i_q_cmd.glyph_line;
                r_scan <= i_q_cmd.scan_line;
                r_col  <= i_q_cmd.cell_column;
                r_end  <= i_q_cmd.frame_end;
            end
            if (r_state == ST_COLOUR) begin
                r_code <= ram_rdata;
            end
            if (r_state == ST_GLYPH) begin
                r_colour <= ram_rdata[3:0];
            end
            if (emit) begin
                r_out <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.pend = r_gpend;

endmodule

// ===== hw/rtl/text_mode_character_renderer.sv =====
`timescale 1ns / 1ps
// Character-mode text renderer with a 64K byte memory image.
// Input channel (i_in_valid/o_in_ready, i_in_data): a store transaction
// writes one byte of the image, a render transaction asks for the next
// group of 8 pixels in raster order over the cell grid.
// Output channel (o_out_valid/i_out_ready, o_out_data): one transaction per
// render with eight palette indices, the scan line, the column and a flag on
// the last group of the frame. Stores give no output.
// The APB port sets the bank mapping, address bit nine and background colour;
// the user must write it only while no transaction is in flight, which the
// block does not enforce. A render holds the single memory port for its reads
// of screen code, colour byte and glyph line, in order, before the next
// command is taken; stores go one per cycle unless a render or stall holds them.
// A 4-entry command queue decouples the input from the memory sequencer.
// When the receiver stalls, one result waits in the output register and one
// more in the memory read register; then the queue fills and o_in_ready drops.
// Reset clears the scan position, the registers and all handshake state; the
// memory image is not cleared and must be written before it is displayed.
`include "assert_macros.svh"

module text_mode_character_renderer #(
    parameter int COLUMNS     = tmcr_pkg::DEF_COLUMNS,
    parameter int ROWS        = tmcr_pkg::DEF_ROWS,
    parameter int QUEUE_DEPTH = tmcr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tmcr_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tmcr_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmcr_pkg::PADDR_W-1:0] paddr,
    input  logic [tmcr_pkg::PDATA_W-1:0] pwdata,
    output logic [tmcr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import tmcr_pkg::*;

    t_cfg       cfg;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    t_back_stat bstat;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    logic       q_overflow;

    tmcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tmcr_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    tmcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_cmd      (head_cmd),
        .o_overflow (q_overflow)
    );

    tmcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_stat      (bstat)
    );

    `ASSERT_ALWAYS(a_queue_bound, !q_overflow, "command queue count exceeds its depth")
    `ASSERT_IMPLIES(a_pop_idle, q_pop, bstat.idle, "queue popped while a render is in progress")
    `ASSERT_IMPLIES(a_out_from_pend, $rose(o_out_valid), $past(bstat.pend), "result without glyph data")
    `ASSERT_IMPLIES(a_frame_end_pos, o_out_valid && o_out_data.frame_end, (o_out_data.cell_column == 5'(COLUMNS - 1)) && (o_out_data.scan_line[2:0] == 3'd7), "frame end flagged off the last cell")

endmodule
